### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the block word decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a synchronous reset that disables the check.
`define GCBWD_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same, on the usual clk and rst of a module.
`define GCBWD_CHECK(label, prop, msg) `GCBWD_ASSERT(label, clk, rst, prop, msg)

`endif

### hw/rtl/gcbwd_pkg.sv
// Package: types, codes and constants of the G-code block word decoder.
`timescale 1ns / 1ps
`default_nettype none

package gcbwd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int NUM_PARAMS      = 15;
  localparam int NUM_GROUPS      = 13;
  localparam int SLOT_W          = 4;
  localparam int N_W             = 7;

  localparam logic [SLOT_W-1:0] SUMMARY_INDEX = 4'd15;

  // floor(v / 1000) = (v * DIV1000_MUL) >> DIV1000_SHIFT for 0 <= v < 100000
  localparam logic [17:0] DIV1000_MUL   = 18'd134218;
  localparam int          DIV1000_SHIFT = 27;
  localparam logic signed [31:0] N_RANGE_LOW  = -32'sd999;
  localparam logic signed [31:0] N_RANGE_HIGH = 32'sd99999;

  localparam logic signed [31:0] G_FEED_THROTTLE = 32'sd94100;
  localparam logic signed [31:0] G_FEED_ADC      = 32'sd94200;
  localparam logic signed [31:0] G_FEED_STABLE   = 32'sd95100;
  localparam logic [N_W-1:0]     G_COORD_FIRST   = 7'd54;

  // block status
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_BAD_LETTER = 3'd1;
  localparam logic [2:0] STATUS_BAD_G      = 3'd2;
  localparam logic [2:0] STATUS_CONFLICT   = 3'd3;
  localparam logic [2:0] STATUS_DUP_PARAM  = 3'd4;

  // mode codes
  localparam logic [2:0] MOTION_RAPID  = 3'd1;
  localparam logic [2:0] MOTION_LINEAR = 3'd2;
  localparam logic [2:0] MOTION_CW     = 3'd3;
  localparam logic [2:0] MOTION_CCW    = 3'd4;
  localparam logic [2:0] MOTION_THREAD = 3'd5;
  localparam logic [2:0] FEED_PER_MIN  = 3'd1;
  localparam logic [2:0] FEED_PER_REV  = 3'd2;
  localparam logic [2:0] FEED_THROTTLE = 3'd3;
  localparam logic [2:0] FEED_ADC      = 3'd4;
  localparam logic [2:0] FEED_STABLE   = 3'd5;
  localparam logic [2:0] PLANE_XY      = 3'd1;
  localparam logic [2:0] PLANE_ZX      = 3'd2;
  localparam logic [2:0] PLANE_YZ      = 3'd3;
  localparam logic [2:0] UNITS_INCH    = 3'd1;
  localparam logic [2:0] UNITS_METRIC  = 3'd2;
  localparam logic [2:0] CYCLE_CANCEL  = 3'd1;
  localparam logic [2:0] CYCLE_DRILL   = 3'd2;
  localparam logic [2:0] CYCLE_PAUSE   = 3'd3;
  localparam logic [2:0] CYCLE_DEEP    = 3'd4;
  localparam logic [2:0] RETURN_HIGH   = 3'd1;
  localparam logic [2:0] RETURN_LOW    = 3'd2;
  localparam logic [2:0] DIST_ABS      = 3'd1;
  localparam logic [2:0] DIST_INC      = 3'd2;

  // modal group masks
  localparam logic [NUM_GROUPS-1:0] GRP_MOVE  = 13'h0001;
  localparam logic [NUM_GROUPS-1:0] GRP_DIST  = 13'h0002;
  localparam logic [NUM_GROUPS-1:0] GRP_UNITS = 13'h0004;
  localparam logic [NUM_GROUPS-1:0] GRP_FEED  = 13'h0008;
  localparam logic [NUM_GROUPS-1:0] GRP_COORD = 13'h0010;
  localparam logic [NUM_GROUPS-1:0] GRP_TLEN  = 13'h0020;
  localparam logic [NUM_GROUPS-1:0] GRP_TRAD  = 13'h0040;
  localparam logic [NUM_GROUPS-1:0] GRP_RET   = 13'h0080;
  localparam logic [NUM_GROUPS-1:0] GRP_PLANE = 13'h0100;
  localparam logic [NUM_GROUPS-1:0] GRP_STOP  = 13'h0200;
  localparam logic [NUM_GROUPS-1:0] GRP_TCHG  = 13'h0400;
  localparam logic [NUM_GROUPS-1:0] GRP_SPIN  = 13'h0800;
  localparam logic [NUM_GROUPS-1:0] GRP_COOL  = 13'h1000;

  // letters
  localparam logic [7:0] LTR_G = 8'h47;
  localparam logic [7:0] LTR_M = 8'h4D;
  localparam logic [7:0] LTR_N = 8'h4E;
  localparam logic [7:0] LTR_C = 8'h43;
  localparam logic [7:0] LTR_X = 8'h58;
  localparam logic [7:0] LTR_Y = 8'h59;
  localparam logic [7:0] LTR_Z = 8'h5A;
  localparam logic [7:0] LTR_A = 8'h41;
  localparam logic [7:0] LTR_B = 8'h42;
  localparam logic [7:0] LTR_I = 8'h49;
  localparam logic [7:0] LTR_J = 8'h4A;
  localparam logic [7:0] LTR_K = 8'h4B;
  localparam logic [7:0] LTR_F = 8'h46;
  localparam logic [7:0] LTR_P = 8'h50;
  localparam logic [7:0] LTR_Q = 8'h51;
  localparam logic [7:0] LTR_S = 8'h53;
  localparam logic [7:0] LTR_R = 8'h52;
  localparam logic [7:0] LTR_D = 8'h44;
  localparam logic [7:0] LTR_L = 8'h4C;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         letter;
    logic signed [31:0] word_value;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         motion_mode;
    logic [2:0]         feed_sel;
    logic [1:0]         plane_sel;
    logic [1:0]         unit_sel;
    logic [2:0]         canned_cycle;
    logic [1:0]         return_level;
    logic [3:0]         mode_flags;
    logic [2:0]         work_offset;
    logic [3:0]         param_index;
    logic signed [31:0] param_value;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    ACT_BAD_LETTER,
    ACT_BAD_G,
    ACT_SKIP,
    ACT_PARAM,
    ACT_MOTION,
    ACT_FEED,
    ACT_PLANE,
    ACT_UNITS,
    ACT_COORD,
    ACT_CYCLE,
    ACT_RETURN,
    ACT_DIST,
    ACT_DWELL,
    ACT_G53
  } act_t;

  typedef struct packed {
    logic [NUM_GROUPS-1:0] grp_mask;
    act_t                  act;
    logic [2:0]            code;
    logic [SLOT_W-1:0]     slot;
  } word_dec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_SUM,
    ST_PARAM
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/gcbwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gcbwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gcbwd_word_dec.sv
// Word decoder: modal group, action and parameter slot of one G-code word.
`timescale 1ns / 1ps
`default_nettype none

module gcbwd_word_dec (
  input  wire logic [7:0]                letter,
  input  wire logic signed [31:0]        word_value,
  input  wire logic [gcbwd_pkg::N_W-1:0] num,
  input  wire logic                      num_ok,
  output gcbwd_pkg::word_dec_t           dec
);

  import gcbwd_pkg::*;

  always_comb begin
    dec          = '0;
    dec.act      = ACT_BAD_LETTER;
    dec.grp_mask = '0;
    case (letter)
      LTR_G: begin
        dec.act = ACT_BAD_G;
        if (word_value == G_FEED_THROTTLE) begin
          dec.grp_mask = GRP_FEED;
          dec.act      = ACT_FEED;
          dec.code     = FEED_THROTTLE;
        end else if (word_value == G_FEED_ADC) begin
          dec.grp_mask = GRP_FEED;
          dec.act      = ACT_FEED;
          dec.code     = FEED_ADC;
        end else if (word_value == G_FEED_STABLE) begin
          dec.grp_mask = GRP_FEED;
          dec.act      = ACT_FEED;
          dec.code     = FEED_STABLE;
        end else if (num_ok) begin
          case (num) inside
            7'd0: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_MOTION; dec.code = MOTION_RAPID;
            end
            7'd1: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_MOTION; dec.code = MOTION_LINEAR;
            end
            7'd2: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_MOTION; dec.code = MOTION_CW;
            end
            7'd3: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_MOTION; dec.code = MOTION_CCW;
            end
            7'd32: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_MOTION; dec.code = MOTION_THREAD;
            end
            7'd4: begin
              dec.act = ACT_DWELL;
            end
            7'd17: begin
              dec.grp_mask = GRP_PLANE; dec.act = ACT_PLANE; dec.code = PLANE_XY;
            end
            7'd18: begin
              dec.grp_mask = GRP_PLANE; dec.act = ACT_PLANE; dec.code = PLANE_ZX;
            end
            7'd19: begin
              dec.grp_mask = GRP_PLANE; dec.act = ACT_PLANE; dec.code = PLANE_YZ;
            end
            7'd20: begin
              dec.grp_mask = GRP_UNITS; dec.act = ACT_UNITS; dec.code = UNITS_INCH;
            end
            7'd21: begin
              dec.grp_mask = GRP_UNITS; dec.act = ACT_UNITS; dec.code = UNITS_METRIC;
            end
            7'd53: begin
              dec.act = ACT_G53;
            end
            [7'd54:7'd58]: begin
              dec.grp_mask = GRP_COORD;
              dec.act      = ACT_COORD;
              dec.code     = 3'(num - (G_COORD_FIRST - 7'd1));
            end
            7'd80: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_CYCLE; dec.code = CYCLE_CANCEL;
            end
            7'd81: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_CYCLE; dec.code = CYCLE_DRILL;
            end
            7'd82: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_CYCLE; dec.code = CYCLE_PAUSE;
            end
            7'd83: begin
              dec.grp_mask = GRP_MOVE; dec.act = ACT_CYCLE; dec.code = CYCLE_DEEP;
            end
            [7'd84:7'd89]: begin
              dec.grp_mask = GRP_MOVE;
            end
            7'd90: begin
              dec.grp_mask = GRP_DIST; dec.act = ACT_DIST; dec.code = DIST_ABS;
            end
            7'd91: begin
              dec.grp_mask = GRP_DIST; dec.act = ACT_DIST; dec.code = DIST_INC;
            end
            7'd94: begin
              dec.grp_mask = GRP_FEED; dec.act = ACT_FEED; dec.code = FEED_PER_MIN;
            end
            7'd95: begin
              dec.grp_mask = GRP_FEED; dec.act = ACT_FEED; dec.code = FEED_PER_REV;
            end
            7'd98: begin
              dec.grp_mask = GRP_RET; dec.act = ACT_RETURN; dec.code = RETURN_HIGH;
            end
            7'd99: begin
              dec.grp_mask = GRP_RET; dec.act = ACT_RETURN; dec.code = RETURN_LOW;
            end
            7'd43, 7'd44, 7'd49: begin
              dec.grp_mask = GRP_TLEN;
            end
            [7'd40:7'd42]: begin
              dec.grp_mask = GRP_TRAD;
            end
            default: begin
              dec.grp_mask = '0;
            end
          endcase
        end
      end
      LTR_M: begin
        dec.act = ACT_SKIP;
        if (num_ok) begin
          case (num) inside
            7'd0, 7'd1, 7'd2, 7'd30, 7'd60: dec.grp_mask = GRP_STOP;
            7'd6:                           dec.grp_mask = GRP_TCHG;
            [7'd3:7'd5]:                    dec.grp_mask = GRP_SPIN;
            [7'd7:7'd9]:                    dec.grp_mask = GRP_COOL;
            default:                        dec.grp_mask = '0;
          endcase
        end
      end
      LTR_N, LTR_C: dec.act = ACT_SKIP;
      LTR_X: begin dec.act = ACT_PARAM; dec.slot = 4'd0;  end
      LTR_Y: begin dec.act = ACT_PARAM; dec.slot = 4'd1;  end
      LTR_Z: begin dec.act = ACT_PARAM; dec.slot = 4'd2;  end
      LTR_A: begin dec.act = ACT_PARAM; dec.slot = 4'd3;  end
      LTR_B: begin dec.act = ACT_PARAM; dec.slot = 4'd4;  end
      LTR_I: begin dec.act = ACT_PARAM; dec.slot = 4'd5;  end
      LTR_J: begin dec.act = ACT_PARAM; dec.slot = 4'd6;  end
      LTR_K: begin dec.act = ACT_PARAM; dec.slot = 4'd7;  end
      LTR_F: begin dec.act = ACT_PARAM; dec.slot = 4'd8;  end
      LTR_P: begin dec.act = ACT_PARAM; dec.slot = 4'd9;  end
      LTR_Q: begin dec.act = ACT_PARAM; dec.slot = 4'd10; end
      LTR_S: begin dec.act = ACT_PARAM; dec.slot = 4'd11; end
      LTR_R: begin dec.act = ACT_PARAM; dec.slot = 4'd12; end
      LTR_D: begin dec.act = ACT_PARAM; dec.slot = 4'd13; end
      LTR_L: begin dec.act = ACT_PARAM; dec.slot = 4'd14; end
      default: dec.act = ACT_BAD_LETTER;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/gcode_block_word_decoder.sv
// Top level: G-code block word decoder with modal group check and parameter store.
//
// Input channel item/item_valid/item_stall: one beat per word (cmd 0) or per
// end of block (cmd 1). Output channel result/result_valid/result_stall.
// For a word beat, the accept cycle registers the word and its
// G/M number (value/1000 by reciprocal multiply), the next cycle decodes it,
// updates the mode registers and writes a parameter into the value RAM.
// Word beats give no result. An end beat gives a mode summary beat, then one
// beat per stored parameter in index order, the final one with last set.
// The summary beat is loaded in the summary state after the end beat and each
// parameter beat in the parameter state (one RAM read per beat); no new input
// beat is taken until the last parameter beat has been loaded.
// The first error of a block is latched and later words are ignored; the
// summary and parameter beats report it and the final beat clears the block.
// Reset clears all mode and flag state and the output valid; the value
// RAM is not cleared, only entries written in the current block are read.
// A stall on the output holds the result register and pauses the readout;
// a word beat can be taken while the final result still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gcode_block_word_decoder #(
  parameter int VALUE_WIDTH = gcbwd_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire gcbwd_pkg::item_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output gcbwd_pkg::result_t     result
);

  import gcbwd_pkg::*;

  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_PARAMS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_PARAMS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  state_t state, state_next;

  logic [7:0]            letter_q;
  logic signed [31:0]    value_q;
  logic [N_W-1:0]        num_q;
  logic                  num_ok_q;

  logic [NUM_GROUPS-1:0] seen;
  logic [NUM_PARAMS-1:0] present;
  logic [NUM_PARAMS-1:0] pend;
  logic [SLOT_W-1:0]     cur_slot;
  logic [2:0]            motion, feed, cycle, coord, err;
  logic [1:0]            plane, units, ret;
  logic [3:0]            flags;

  logic [34:0]           div_prod;
  logic                  item_acc;
  logic                  out_free;
  logic                  ld_sum, ld_par, ld_last;
  logic                  word_live, word_dead, conflict;
  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [SLOT_W-1:0]     next_slot;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic signed [VALUE_WIDTH-1:0] ram_wdata, rd_value;
  word_dec_t             dec;

  assign item_acc  = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign div_prod  = 35'(item.word_value[16:0]) * 35'(DIV1000_MUL);
  assign word_live = (state == ST_WORD) && (err == STATUS_OK);
  assign word_dead = (state == ST_WORD) && (err != STATUS_OK);
  assign conflict  = |(seen & dec.grp_mask);
  assign ram_wdata = VALUE_WIDTH'(value_q);
  assign rd_value  = ram_rdata;
  assign next_slot = (state == ST_SUM) ? first_set(present) : first_set(pend);

  gcbwd_word_dec u_dec (
    .letter     (letter_q),
    .word_value (value_q),
    .num        (num_q),
    .num_ok     (num_ok_q),
    .dec        (dec)
  );

  gcbwd_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (NUM_PARAMS)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dec.slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (item_acc) state_next = item.cmd ? ST_SUM : ST_WORD;
      ST_WORD:  state_next = ST_IDLE;
      ST_SUM:   if (out_free) state_next = (present == '0) ? ST_IDLE : ST_PARAM;
      ST_PARAM: if (out_free && pend == '0) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    ld_sum     = (state == ST_SUM) && out_free;
    ld_par     = (state == ST_PARAM) && out_free;
    ld_last    = (ld_sum && present == '0) || (ld_par && pend == '0);
    ram_we     = word_live && !conflict && dec.act == ACT_PARAM && !present[dec.slot];
    ram_re     = ld_sum || (ld_par && pend != '0);
    ram_raddr  = next_slot;
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      letter_q <= item.letter;
      value_q  <= item.word_value;
      if (item.word_value >= 32'sd0 && item.word_value <= N_RANGE_HIGH) begin
        num_q    <= div_prod[DIV1000_SHIFT +: N_W];
        num_ok_q <= 1'b1;
      end else begin
        num_q    <= '0;
        num_ok_q <= (item.word_value >= N_RANGE_LOW) && (item.word_value < 32'sd0);
      end
    end
    if (ld_sum) begin
      result.status       <= err;
      result.motion_mode  <= motion;
      result.feed_sel     <= feed;
      result.plane_sel    <= plane;
      result.unit_sel     <= units;
      result.canned_cycle <= cycle;
      result.return_level <= ret;
      result.mode_flags   <= flags;
      result.work_offset  <= coord;
      result.param_index  <= SUMMARY_INDEX;
      result.param_value  <= '0;
      result.last         <= ld_last;
    end else if (ld_par) begin
      result.status       <= err;
      result.motion_mode  <= '0;
      result.feed_sel     <= '0;
      result.plane_sel    <= '0;
      result.unit_sel     <= '0;
      result.canned_cycle <= '0;
      result.return_level <= '0;
      result.mode_flags   <= '0;
      result.work_offset  <= '0;
      result.param_index  <= cur_slot;
      result.param_value  <= 32'(rd_value);
      result.last         <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      seen         <= '0;
      present      <= '0;
      pend         <= '0;
      cur_slot     <= '0;
      motion       <= '0;
      feed         <= '0;
      plane        <= '0;
      units        <= '0;
      cycle        <= '0;
      ret          <= '0;
      flags        <= '0;
      coord        <= '0;
      err          <= STATUS_OK;
    end else begin
      state <= state_next;
      if (ld_sum || ld_par) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (ram_re) begin
        cur_slot <= next_slot;
        pend     <= ((state == ST_SUM) ? present : pend)
                    & ~(NUM_PARAMS'(1) << next_slot);
      end
      if (word_live) begin
        if (conflict) begin
          err <= STATUS_CONFLICT;
        end else begin
          seen <= seen | dec.grp_mask;
          case (dec.act)
            ACT_BAD_LETTER: err    <= STATUS_BAD_LETTER;
            ACT_BAD_G:      err    <= STATUS_BAD_G;
            ACT_SKIP:       err    <= STATUS_OK;
            ACT_PARAM: begin
              if (present[dec.slot]) begin
                err <= STATUS_DUP_PARAM;
              end else begin
                present[dec.slot] <= 1'b1;
              end
            end
            ACT_MOTION:     motion <= dec.code;
            ACT_FEED:       feed   <= dec.code;
            ACT_PLANE:      plane  <= dec.code[1:0];
            ACT_UNITS:      units  <= dec.code[1:0];
            ACT_COORD:      coord  <= dec.code;
            ACT_CYCLE:      cycle  <= dec.code;
            ACT_RETURN:     ret    <= dec.code[1:0];
            ACT_DIST:       flags  <= {dec.code[1:0], flags[1:0]};
            ACT_DWELL:      flags  <= flags | 4'b0001;
            ACT_G53:        flags  <= flags | 4'b0010;
            default:        err    <= STATUS_BAD_LETTER;
          endcase
        end
      end
      if (ld_last) begin
        seen    <= '0;
        present <= '0;
        motion  <= '0;
        feed    <= '0;
        plane   <= '0;
        units   <= '0;
        cycle   <= '0;
        ret     <= '0;
        flags   <= '0;
        coord   <= '0;
        err     <= STATUS_OK;
      end
    end
  end

  `GCBWD_CHECK(a_par_present, ld_par |-> present[cur_slot], "readout of an absent parameter")
  `GCBWD_CHECK(a_no_write_in_dump, ram_we |-> (pend == '0), "value write during readout")
  `GCBWD_CHECK(a_err_keeps_present, word_dead |=> $stable(present), "word after error stored")
  `GCBWD_CHECK(a_err_keeps_seen, word_dead |=> $stable(seen), "word after error took a group")

endmodule

`default_nettype wire
